// ===== hw/rtl/mtsu_pkg.sv =====
package mtsu_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 64;

    localparam int NOTE_POS_W = 7;
    localparam int FREQ_W     = 16;
    localparam int MS_W       = 16;
    localparam int HALF_W     = 22;
    localparam int DIV_W      = 24;
    localparam int DIVISOR_W  = FREQ_W + 1;
    localparam int WORD_W     = FREQ_W + MS_W;

    localparam int TONE_CLOCK_HZ = 10000000;
    localparam int GAP_HZ        = 2;

    localparam logic [DIV_W-1:0]  DIVIDEND = DIV_W'(TONE_CLOCK_HZ);
    localparam logic [HALF_W-1:0] HALF_MAX = '1;
    localparam logic [HALF_W-1:0] GAP_HALF = HALF_W'(TONE_CLOCK_HZ / (2 * GAP_HZ));
    localparam logic [FREQ_W-1:0] REST_HZ  = FREQ_W'(20);
    localparam logic [MS_W-1:0]   GAP_MS   = MS_W'(10);

    localparam logic REG_IDX_NOTE_COUNT = 1'b0;

    typedef enum logic [1:0] {
        FUNC_MS_TICK   = 2'd0,
        FUNC_TONE_TICK = 2'd1,
        FUNC_WRITE     = 2'd2,
        FUNC_START     = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        PH_GAP_START  = 2'd0,
        PH_GAP_WAIT   = 2'd1,
        PH_NOTE_START = 2'd2,
        PH_NOTE_WAIT  = 2'd3
    } phase_t;

    typedef struct packed {
        logic                 start;
        logic [DIVISOR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== hw/rtl/mtsu_chan_if.sv =====
interface mtsu_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [5:0]  note_addr;
    logic [15:0] note_freq;
    logic [15:0] note_ms;

    modport source (output valid, func, note_addr, note_freq, note_ms, input ready);
    modport sink (input valid, func, note_addr, note_freq, note_ms, output ready);
endinterface

interface mtsu_out_if;
    logic       valid;
    logic       ready;
    logic       speaker;
    logic       playing;
    logic [6:0] current_note;
    logic [1:0] phase;

    modport source (output valid, speaker, playing, current_note, phase, input ready);
    modport sink (input valid, speaker, playing, current_note, phase, output ready);
endinterface

// ===== hw/rtl/mtsu_note_mem.sv =====
module mtsu_note_mem
    import mtsu_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    localparam int AW = $clog2(TABLE_DEPTH)
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [WORD_W-1:0] wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output logic [WORD_W-1:0] rdata
);

    logic [WORD_W-1:0] mem [TABLE_DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/mtsu_div.sv =====
module mtsu_div
    import mtsu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_W = $clog2(DIV_W);
    localparam int REM_W = DIVISOR_W + 1;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic [DIV_W-1:0]     dq_reg, dq_next;
    logic [DIVISOR_W-1:0] dsr_reg, dsr_next;
    logic [REM_W-1:0]     rem_sh;
    logic                 fits;

    // one quotient bit per cycle, restoring
    assign rem_sh = {rem_reg[REM_W-2:0], dq_reg[DIV_W-1]};
    assign fits   = rem_sh >= {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        dsr_next  = dsr_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dq_next   = DIVIDEND;
            dsr_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? rem_sh - {1'b0, dsr_reg} : rem_sh;
            dq_next  = {dq_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = dq_reg;

endmodule

// ===== hw/rtl/melody_tone_sequencer_unit.sv =====
// path: tone ticks, writes, plain starts and most ms ticks go from the input transfer
// to the output register; an ms tick reading the note duration passes the table read;
// a note frequency load passes table read, divider start and 24 divider steps
// throughput: one item at a time, the next is taken once the previous is loaded, later
// while a finished transfer waits in the output register
// reset: asynchronous, active low; clears sequencer, tone state and note_count, table kept
module melody_tone_sequencer_unit
    import mtsu_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    mtsu_in_if.sink     in_chan,
    mtsu_out_if.source  out_chan
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int XW = (AW > NOTE_POS_W) ? AW : NOTE_POS_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t                state_reg, state_next;
    logic                  play_reg, play_next;
    phase_t                phase_reg, phase_next;
    logic [MS_W-1:0]       ms_reg, ms_next;
    logic [NOTE_POS_W-1:0] pos_reg, pos_next;
    logic [HALF_W-1:0]     half_reg, half_next;
    logic [HALF_W-1:0]     tone_reg, tone_next;
    logic                  pin_reg, pin_next;
    logic                  rd_dur_reg, rd_dur_next;
    logic [NOTE_POS_W-1:0] note_count_reg;
    logic                  out_valid_reg;
    logic                  out_load;

    logic                  out_speaker_reg;
    logic                  out_playing_reg;
    logic [NOTE_POS_W-1:0] out_note_reg;
    logic [1:0]            out_phase_reg;

    logic                  mem_we;
    logic                  mem_re;
    logic [AW-1:0]         mem_raddr;
    logic [WORD_W-1:0]     mem_rdata;
    logic [XW-1:0]         pos_x;
    logic [XW-1:0]         addr_x;
    logic [AW-1:0]         pos_idx;
    logic [AW-1:0]         addr_idx;

    logic [MS_W-1:0]       ms_inc;
    logic                  note_valid;
    logic                  addr_ok;
    logic [FREQ_W-1:0]     rd_freq;
    logic [MS_W-1:0]       rd_ms;
    logic [FREQ_W-1:0]     hz;
    logic [HALF_W-1:0]     half_sat;
    logic [HALF_W-1:0]     tone_inc;
    logic                  cfg_wr;

    div_req_t              div_req;
    div_rsp_t              div_rsp;

    // configuration
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_IDX_NOTE_COUNT);
    assign prdata = (paddr[2] == REG_IDX_NOTE_COUNT) ? 32'(note_count_reg) : '0;

    // table indexes
    assign pos_x    = XW'(pos_reg);
    assign addr_x   = XW'(in_chan.note_addr);
    assign pos_idx  = pos_x[AW-1:0];
    assign addr_idx = addr_x[AW-1:0];

    assign ms_inc     = (ms_reg != '1) ? ms_reg + MS_W'(1) : ms_reg;
    assign note_valid = (pos_reg < note_count_reg) && (32'(pos_reg) < 32'(TABLE_DEPTH));
    assign addr_ok    = 32'(in_chan.note_addr) < 32'(TABLE_DEPTH);
    assign rd_freq    = mem_rdata[WORD_W-1:MS_W];
    assign rd_ms      = mem_rdata[MS_W-1:0];
    assign hz         = (rd_freq == '0) ? REST_HZ : rd_freq;
    assign half_sat   = (div_rsp.quotient > DIV_W'(HALF_MAX)) ? HALF_MAX
                                                              : div_rsp.quotient[HALF_W-1:0];
    assign tone_inc   = tone_reg + HALF_W'(1);

    assign in_chan.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        play_next       = play_reg;
        phase_next      = phase_reg;
        ms_next         = ms_reg;
        pos_next        = pos_reg;
        half_next       = half_reg;
        tone_next       = tone_reg;
        pin_next        = pin_reg;
        rd_dur_next     = rd_dur_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_raddr       = pos_idx;
        div_req.start   = 1'b0;
        div_req.divisor = {hz, 1'b0};
        out_load        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_chan.valid)
                begin
                    state_next = S_DONE;
                    case (func_t'(in_chan.func))
                        FUNC_MS_TICK:
                        begin
                            ms_next = ms_inc;
                            if (play_reg)
                            begin
                                case (phase_reg)
                                    PH_GAP_START:
                                    begin
                                        ms_next    = '0;
                                        phase_next = PH_GAP_WAIT;
                                        half_next  = GAP_HALF;
                                        tone_next  = '0;
                                    end
                                    PH_GAP_WAIT:
                                    begin
                                        if (ms_inc >= GAP_MS)
                                        begin
                                            phase_next = PH_NOTE_START;
                                        end
                                    end
                                    PH_NOTE_START:
                                    begin
                                        ms_next = '0;
                                        if (note_valid)
                                        begin
                                            mem_re      = 1'b1;
                                            rd_dur_next = 1'b0;
                                            phase_next  = PH_NOTE_WAIT;
                                            state_next  = S_READ;
                                        end
                                        else
                                        begin
                                            play_next  = 1'b0;
                                            pos_next   = '0;
                                            phase_next = PH_GAP_START;
                                        end
                                    end
                                    PH_NOTE_WAIT:
                                    begin
                                        if (!note_valid)
                                        begin
                                            pos_next   = pos_reg + NOTE_POS_W'(1);
                                            ms_next    = '0;
                                            phase_next = PH_GAP_START;
                                        end
                                        else
                                        begin
                                            mem_re      = 1'b1;
                                            rd_dur_next = 1'b1;
                                            state_next  = S_READ;
                                        end
                                    end
                                    default:
                                    begin
                                        phase_next = PH_GAP_START;
                                    end
                                endcase
                            end
                        end
                        FUNC_TONE_TICK:
                        begin
                            if (half_reg != '0)
                            begin
                                if (tone_inc >= half_reg)
                                begin
                                    tone_next = '0;
                                    pin_next  = !pin_reg;
                                end
                                else
                                begin
                                    tone_next = tone_inc;
                                end
                            end
                        end
                        FUNC_WRITE:
                        begin
                            mem_we = addr_ok;
                        end
                        FUNC_START:
                        begin
                            play_next = 1'b1;
                            pos_next  = '0;
                            if (phase_reg == PH_GAP_START)
                            begin
                                mem_re      = 1'b1;
                                mem_raddr   = '0;
                                rd_dur_next = 1'b0;
                                state_next  = S_READ;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                if (rd_dur_reg)
                begin
                    if (ms_reg >= rd_ms)
                    begin
                        pos_next   = pos_reg + NOTE_POS_W'(1);
                        ms_next    = '0;
                        phase_next = PH_GAP_START;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    half_next  = half_sat;
                    tone_next  = '0;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_chan.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            play_reg       <= 1'b0;
            phase_reg      <= PH_GAP_START;
            ms_reg         <= '0;
            pos_reg        <= '0;
            half_reg       <= '0;
            tone_reg       <= '0;
            pin_reg        <= 1'b0;
            rd_dur_reg     <= 1'b0;
            note_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            play_reg   <= play_next;
            phase_reg  <= phase_next;
            ms_reg     <= ms_next;
            pos_reg    <= pos_next;
            half_reg   <= half_next;
            tone_reg   <= tone_next;
            pin_reg    <= pin_next;
            rd_dur_reg <= rd_dur_next;
            if (cfg_wr)
            begin
                note_count_reg <= pwdata[NOTE_POS_W-1:0];
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_chan.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output register, loaded once the item's state is final
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_speaker_reg <= pin_reg;
            out_playing_reg <= play_reg;
            out_note_reg    <= pos_reg;
            out_phase_reg   <= phase_reg;
        end
    end

    assign out_chan.valid        = out_valid_reg;
    assign out_chan.speaker      = out_speaker_reg;
    assign out_chan.playing      = out_playing_reg;
    assign out_chan.current_note = out_note_reg;
    assign out_chan.phase        = out_phase_reg;

    mtsu_note_mem #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_note_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (addr_idx),
        .wdata ({in_chan.note_freq, in_chan.note_ms}),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    mtsu_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

endmodule

// ===== hw/rtl/mtsu_checker.sv =====
module mtsu_checker
    import mtsu_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        out_speaker,
    input logic        out_playing,
    input logic [6:0]  out_current_note,
    input logic [1:0]  out_phase
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_speaker) && $stable(out_playing)
            && $stable(out_current_note) && $stable(out_phase))
    else $error("stalled result changed");

    // one item at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

    // stopped sequencer sits at note 0, gap start
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_playing |-> out_current_note == '0 && out_phase == PH_GAP_START)
    else $error("idle sequencer not rewound");

    // note_count readback
    assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && paddr[2] == REG_IDX_NOTE_COUNT
        |=> paddr[2] != REG_IDX_NOTE_COUNT || prdata == 32'($past(pwdata[6:0])))
    else $error("note_count readback mismatch");

endmodule

bind melody_tone_sequencer_unit mtsu_checker u_mtsu_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .in_valid         (in_chan.valid),
    .in_ready         (in_chan.ready),
    .out_valid        (out_chan.valid),
    .out_ready        (out_chan.ready),
    .out_speaker      (out_chan.speaker),
    .out_playing      (out_chan.playing),
    .out_current_note (out_chan.current_note),
    .out_phase        (out_chan.phase)
);
